[src/rpn_stack_calculator_unit_macros.svh]
// Assertion helpers for the calculator checker
`ifndef RPN_STACK_CALCULATOR_UNIT_MACROS_SVH
`define RPN_STACK_CALCULATOR_UNIT_MACROS_SVH

// clocked, disabled during reset
`define RSC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rsc checker: property failed");

// clocked, also checked during reset
`define RSC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rsc checker: property failed");

`endif

[src/rsc_pkg.sv]
`timescale 1ns / 1ps

package rsc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int CMD_W           = 3;
    localparam int DATA_W          = 32;
    localparam int DEPTH_W         = 7;
    localparam int STATUS_W        = 3;
    localparam int OUT_TDATA_W     = 48;
    localparam int OUT_PAD_W       = OUT_TDATA_W - DATA_W - DEPTH_W - STATUS_W;
    localparam int DIV_STEPS       = 48;
    localparam int STEP_W          = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0] Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN       = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MINUS_ONE_Q = 32'hFFFF_0000;
    localparam logic [63:0]       ROUND_HALF  = 64'h0000_0000_0000_8000;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SUB     = 3'd2,
        CMD_MUL     = 3'd3,
        CMD_DIV     = 3'd4,
        CMD_DISCARD = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVF   = 3'd2,
        ST_DZ    = 3'd3,
        ST_SAT   = 3'd4
    } status_t;

    typedef struct packed {
        logic done;
        logic sat;
        logic dz;
    } alu_stat_t;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] value;
    } clamp_t;

    // signed result from a magnitude, saturated to Q16.16 range
    function automatic clamp_t clamp_mag(input logic [47:0] mag, input logic neg);
        clamp_t c;
        if (!neg)
        begin
            c.sat   = mag > 48'h0000_7FFF_FFFF;
            c.value = c.sat ? Q_MAX : mag[DATA_W-1:0];
        end
        else
        begin
            c.sat   = mag > 48'h0000_8000_0000;
            c.value = c.sat ? Q_MIN : (~mag[DATA_W-1:0] + 32'd1);
        end
        return c;
    endfunction

endpackage

[src/rsc_stack_mem.sv]
`timescale 1ns / 1ps

module rsc_stack_mem
    import rsc_pkg::*;
#(
    parameter  int DEPTH  = STACK_DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/rsc_alu.sv]
`timescale 1ns / 1ps

module rsc_alu
    import rsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cmd_t              op,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [DATA_W-1:0] result,
    output alu_stat_t         stat
);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_FIN  = 4'b1000
    } alu_state_t;

    alu_state_t        state_reg, state_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [63:0]       prod_reg;
    logic [47:0]       dvd_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] result_reg;
    logic              sat_reg;
    logic              dz_reg;

    logic [DATA_W-1:0] mag_a, mag_b;
    logic [DATA_W:0]   sum;
    logic [63:0]       rnd;
    logic [DATA_W:0]   rem_sh;
    logic              ge;
    logic [DATA_W:0]   rem_sub;
    clamp_t            mul_c, div_c;

    assign mag_a  = a[DATA_W-1] ? (~a + 32'd1) : a;
    assign mag_b  = b[DATA_W-1] ? (~b + 32'd1) : b;
    assign sum    = (op == CMD_SUB) ? ({a[DATA_W-1], a} - {b[DATA_W-1], b})
                                    : ({a[DATA_W-1], a} + {b[DATA_W-1], b});
    assign rnd    = prod_reg + ROUND_HALF;
    assign mul_c  = clamp_mag(rnd[63:16], neg_reg);
    assign div_c  = clamp_mag(dvd_reg, neg_reg);

    // restoring divide, one quotient bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[47]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    case (op) inside
                        CMD_MUL:  state_next = A_MUL;
                        CMD_DIV:
                        begin
                            if (b == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = A_DIV;
                                step_next  = '0;
                            end
                        end
                        default:  done_next = 1'b1;
                    endcase
                end
            end
            A_MUL:
            begin
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            A_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = A_FIN;
                end
            end
            A_FIN:
            begin
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    neg_reg  <= a[DATA_W-1] ^ b[DATA_W-1];
                    prod_reg <= 64'(mag_a) * 64'(mag_b);
                    dvd_reg  <= {mag_a, 16'h0000};
                    rem_reg  <= '0;
                    den_reg  <= mag_b;
                    dz_reg   <= 1'b0;
                    sat_reg  <= 1'b0;
                    case (op) inside
                        CMD_ADD, CMD_SUB:
                        begin
                            sat_reg    <= sum[DATA_W] != sum[DATA_W-1];
                            result_reg <= (sum[DATA_W] != sum[DATA_W-1])
                                        ? (sum[DATA_W] ? Q_MIN : Q_MAX)
                                        : sum[DATA_W-1:0];
                        end
                        CMD_DIV:
                        begin
                            if (b == '0)
                            begin
                                dz_reg     <= 1'b1;
                                result_reg <= a[DATA_W-1] ? Q_MIN
                                            : ((a == '0) ? '0 : Q_MAX);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                sat_reg    <= mul_c.sat;
                result_reg <= mul_c.value;
            end
            A_DIV:
            begin
                rem_reg <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                dvd_reg <= {dvd_reg[46:0], ge};
            end
            A_FIN:
            begin
                sat_reg    <= div_c.sat;
                result_reg <= div_c.value;
            end
            default:
            begin
            end
        endcase
    end

    assign result    = result_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign stat.dz   = dz_reg;

endmodule

[src/rpn_stack_calculator_unit.sv]
`timescale 1ns / 1ps
// RPN evaluator on a bounded stack of signed Q16.16 entries.
// Input words: s_axis_tuser carries the command (push, add, sub, mul, div,
// discard two), s_axis_tdata the operand for a push. One input word gives
// exactly one output word: new top (-1.0 when empty), depth and status.
// Items are processed one at a time; s_axis_tready is high only while the
// sequencer is idle. A push or an unused command goes straight to the
// output register; discard two first reads the stack; add, subtract,
// multiply and divide also read the stack and then wait on the ALU, where
// divide runs 48 quotient bits through the restoring divider, one per cycle.
// The next word is taken the cycle after the result enters the output
// register; a result waiting on m_axis_tready does not block that, but a
// second finished result waits until the first one is taken.
// Reset (rst_n low, asynchronous) empties the stack and drops any pending
// output. Stack storage is not cleared; only data from live entries is ever used.
module rpn_stack_calculator_unit
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,  // operand_value
    input  logic [CMD_W-1:0]       s_axis_tuser,  // command
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // top_value, stack_depth, status, zero pad
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_OPER = 5'b00100,
        S_WAIT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [DATA_W-1:0]      top_reg, top_next;
    status_t                status_reg, status_next;
    logic                   under_reg, under_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic                   out_load;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [DATA_W-1:0]      wr_data;
    logic [CNT_W-1:0]       rd_ptr;
    logic [DATA_W-1:0]      rd_data;

    logic                   alu_start;
    logic [DATA_W-1:0]      alu_a, alu_b, alu_result;
    alu_stat_t              alu_stat;

    cmd_t                   in_cmd;
    logic                   ge1, ge2, ge3;
    logic [CNT_W-1:0]       base_cnt;

    assign in_cmd   = cmd_t'(s_axis_tuser);
    assign ge1      = count_reg >= CNT_W'(1);
    assign ge2      = count_reg >= CNT_W'(2);
    assign ge3      = count_reg >= CNT_W'(3);
    assign base_cnt = ge2 ? (count_reg - CNT_W'(2)) : '0;

    // left operand for an operation, new top for a discard
    assign rd_ptr = (cmd_reg == CMD_DISCARD) ? (count_reg - CNT_W'(3))
                                             : (count_reg - CNT_W'(2));
    assign alu_a  = ge2 ? rd_data : MINUS_ONE_Q;
    assign alu_b  = ge1 ? top_reg : MINUS_ONE_Q;

    rsc_stack_mem #(
        .DEPTH(STACK_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_ptr[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    rsc_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (cmd_reg),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_result),
        .stat   (alu_stat)
    );

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        status_next = status_reg;
        under_next  = under_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[ADDR_W-1:0];
        wr_data     = s_axis_tdata;
        alu_start   = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next    = in_cmd;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (in_cmd) inside
                        CMD_PUSH:
                        begin
                            if (count_reg < CNT_W'(STACK_DEPTH))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                top_next   = s_axis_tdata;
                            end
                            else
                            begin
                                status_next = ST_OVF;
                            end
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_DISCARD:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_OPER;
            end
            S_OPER:
            begin
                under_next = !ge2;
                count_next = base_cnt;
                if (cmd_reg == CMD_DISCARD)
                begin
                    top_next    = ge3 ? rd_data : MINUS_ONE_Q;
                    status_next = ge2 ? ST_OK : ST_UNDER;
                    state_next  = S_DONE;
                end
                else
                begin
                    alu_start  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (alu_stat.done)
                begin
                    wr_en      = 1'b1;
                    wr_data    = alu_result;
                    count_next = count_reg + CNT_W'(1);
                    top_next   = alu_result;
                    if (alu_stat.dz)
                    begin
                        status_next = ST_DZ;
                    end
                    else if (alu_stat.sat)
                    begin
                        status_next = ST_SAT;
                    end
                    else if (under_reg)
                    begin
                        status_next = ST_UNDER;
                    end
                    else
                    begin
                        status_next = ST_OK;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_PUSH;
            count_reg     <= '0;
            top_reg       <= MINUS_ONE_Q;
            status_reg    <= ST_OK;
            under_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            status_reg    <= status_next;
            under_reg     <= under_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {OUT_PAD_W'(0), status_reg, DEPTH_W'(count_reg), top_reg};
        end
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[src/rsc_checker.sv]
`timescale 1ns / 1ps
`include "rpn_stack_calculator_unit_macros.svh"

module rsc_checker
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic             small_stack;
    logic [DATA_W-1:0] out_top;
    logic [DEPTH_W-1:0] out_depth;
    logic [STATUS_W-1:0] out_status;

    assign small_stack = STACK_DEPTH < 128;
    assign out_top     = m_axis_tdata[DATA_W-1:0];
    assign out_depth   = m_axis_tdata[DATA_W+DEPTH_W-1:DATA_W];
    assign out_status  = m_axis_tdata[DATA_W+DEPTH_W+STATUS_W-1:DATA_W+DEPTH_W];

    // stalled word holds
    `RSC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // one word in flight: no accept on the cycle after an accept
    `RSC_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    `RSC_ASSERT(a_status_range, m_axis_tvalid |-> out_status <= 3'(ST_SAT))

    `RSC_ASSERT(a_depth_range, m_axis_tvalid && small_stack |-> out_depth <= DEPTH_W'(STACK_DEPTH))

    // empty stack reports -1.0
    `RSC_ASSERT_ALWAYS(a_empty_top, rst_n && m_axis_tvalid && small_stack && out_depth == '0 |-> out_top == MINUS_ONE_Q)

endmodule

bind rpn_stack_calculator_unit rsc_checker #(
    .STACK_DEPTH(STACK_DEPTH)
) u_rsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
